// ===== sv/process_priority_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the process priority queue
// Shorthand for clocked concurrent checks, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PROCESS_PRIORITY_QUEUE_MACROS_SVH
`define PROCESS_PRIORITY_QUEUE_MACROS_SVH

// condition holds at every clock edge outside reset
`define PPQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define PPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ppq_pkg.sv =====
// ---------------------------------------------------------------------------
// Process priority queue package
// Sizes, command and status codes, and the types shared by the queue cells.
// ---------------------------------------------------------------------------
package ppq_pkg;

   localparam int DEPTH     = 16;
   localparam int PID_BITS  = 16;
   localparam int PRIO_BITS = 8;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int OCC_W     = 5;

   localparam logic [1:0] CMD_APPEND  = 2'd0;
   localparam logic [1:0] CMD_INSERT  = 2'd1;
   localparam logic [1:0] CMD_DEQUEUE = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [PID_BITS-1:0]  pid;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   // broadcast from the queue control to every cell
   typedef struct packed {
      logic                 go;
      logic [1:0]           cmd;
      logic                 full;
      logic [CNT_W-1:0]     count;
      logic [PID_BITS-1:0]  pid;
      logic [PRIO_BITS-1:0] prio;
   } ctrl_type;

   typedef struct packed {
      logic [PID_BITS-1:0]  pid;
      logic [PRIO_BITS-1:0] prio;
      logic [1:0]           status;
      logic [OCC_W-1:0]     occupancy;
   } result_type;

endpackage

// ===== sv/ppq_cell.sv =====
// ---------------------------------------------------------------------------
// Queue cell
// Holds one entry; takes a new entry, its left or right neighbor, or holds.
// ---------------------------------------------------------------------------
module ppq_cell (
   input  logic                   clock,
   input  ppq_pkg::ctrl_type      ctrl,
   input  logic [ppq_pkg::IDX_W-1:0] idx,
   input  ppq_pkg::entry_type     left_entry,
   input  ppq_pkg::entry_type     right_entry,
   input  logic                   found_in,
   output logic                   found_out,
   output ppq_pkg::entry_type     entry
);
   import ppq_pkg::*;

   entry_type entry_ff, entry_in;
   entry_type new_entry;
   logic      occupied, at_tail, gt;

   assign new_entry = '{pid: ctrl.pid, prio: ctrl.prio};
   assign occupied  = CNT_W'(idx) < ctrl.count;
   assign at_tail   = CNT_W'(idx) == ctrl.count;
   assign gt        = occupied && (ctrl.prio < entry_ff.prio);
   assign found_out = found_in | gt;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.go) begin
         case (ctrl.cmd)
            CMD_APPEND: begin
               if (!ctrl.full && at_tail) entry_in = new_entry;
            end
            CMD_INSERT: begin
               // shift up behind the insertion point, place at the first larger priority
               if (!ctrl.full) begin
                  if (found_in) entry_in = left_entry;
                  else if (gt || at_tail) entry_in = new_entry;
               end
            end
            CMD_DEQUEUE: entry_in = right_entry;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== sv/ppq_out_fifo.sv =====
// ---------------------------------------------------------------------------
// Result buffer
// Two-entry queue of result items between the cell row and the output.
// ---------------------------------------------------------------------------
module ppq_out_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ppq_pkg::result_type din,
   input  logic                pop,
   output logic                valid,
   output logic                full,
   output ppq_pkg::result_type dout
);
   import ppq_pkg::*;

   result_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign valid  = count_ff != 2'd0;
   assign full   = count_ff == 2'd2;
   assign dout   = mem_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= din;
   end

endmodule

// ===== sv/process_priority_queue.sv =====
// ---------------------------------------------------------------------------
// Process priority queue
// Bounded queue of process entries with tail append, priority insert with
// first-come-first-served ties, and front dequeue.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: tuser[1:0] command (0 append, 1 insert by priority,
//   2 dequeue); tdata holds pid and prio. One command is one item.
//   rsp channel: one result item per command; tuser[1:0] status (0 done,
//   1 dequeue on empty, 2 append or insert dropped because full), tdata
//   holds the removed pid and prio (zero unless a dequeue succeeded) and
//   the occupancy after the command.
//   Each entry lives in one cell of a row; every cell compares its priority
//   with the incoming one in parallel and the insertion point ripples along
//   the row, so all cells update in the accept cycle. One command is taken
//   per cycle while req_tready is high; its result is queued for rsp.
//   A two-item result buffer sits before rsp: while the receiver stalls, one
//   more command is taken, then req_tready drops until a result is taken.
//   Reset empties the queue at once (entry contents are not cleared).
// ---------------------------------------------------------------------------
`include "process_priority_queue_macros.svh"

module process_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [15:0] pid, [23:16] prio
   input  logic [1:0]  req_tuser,  // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [15:0] out_pid, [23:16] out_prio,
                                   // [28:24] occupancy, [31:29] zero
   output logic [1:0]  rsp_tuser   // [1:0] status
);
   import ppq_pkg::*;

   logic             accept;
   logic             fifo_full;
   logic [CNT_W-1:0] count_ff, count_in;
   ctrl_type         ctrl;
   entry_type        cell_q [DEPTH];
   logic [DEPTH:0]   found;
   entry_type        new_entry;
   result_type       result, rsp_result;
   logic             is_ins, is_deq, full, empty;

   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;

   assign full   = count_ff == CNT_W'(DEPTH);
   assign empty  = count_ff == '0;
   assign is_ins = (req_tuser == CMD_APPEND) || (req_tuser == CMD_INSERT);
   assign is_deq = req_tuser == CMD_DEQUEUE;

   assign ctrl.go    = accept;
   assign ctrl.cmd   = req_tuser;
   assign ctrl.full  = full;
   assign ctrl.count = count_ff;
   assign ctrl.pid   = req_tdata[PID_BITS-1:0];
   assign ctrl.prio  = req_tdata[16 +: PRIO_BITS];
   assign new_entry  = '{pid: ctrl.pid, prio: ctrl.prio};

   assign found[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      if (i == 0) begin : g_first
         assign left_e = new_entry;
      end else begin : g_mid
         assign left_e = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_e = cell_q[i];
      end else begin : g_inner
         assign right_e = cell_q[i+1];
      end
      ppq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .idx         (IDX_W'(i)),
         .left_entry  (left_e),
         .right_entry (right_e),
         .found_in    (found[i]),
         .found_out   (found[i+1]),
         .entry       (cell_q[i])
      );
   end

   always_comb begin
      count_in         = count_ff;
      result.pid       = '0;
      result.prio      = '0;
      result.status    = ST_DONE;
      if (is_ins) begin
         if (full) result.status = ST_FULL;
         else count_in = count_ff + CNT_W'(1);
      end else if (is_deq) begin
         if (empty) begin
            result.status = ST_EMPTY;
         end else begin
            result.pid  = cell_q[0].pid;
            result.prio = cell_q[0].prio;
            count_in    = count_ff - CNT_W'(1);
         end
      end
      result.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   ppq_out_fifo u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .din   (result),
      .pop   (rsp_tready),
      .valid (rsp_tvalid),
      .full  (fifo_full),
      .dout  (rsp_result)
   );

   assign rsp_tdata = {3'b000, rsp_result.occupancy, rsp_result.prio, rsp_result.pid};
   assign rsp_tuser = rsp_result.status;

   `PPQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "fill count beyond depth")
   `PPQ_ASSERT_NEXT(a_full_drop, accept && is_ins && full, full, "full insert changed count")
   `PPQ_ASSERT_NEXT(a_empty_deq, accept && is_deq && empty, empty, "empty dequeue changed count")
   `PPQ_ASSERT_NEXT(a_rsp_after_accept, accept, rsp_tvalid, "accepted command produced no result")

endmodule
